### rtl/core/note_biquad_cascade_filterbank_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the note biquad filterbank
// Shared property forms; clk and rst_n come from the using scope.
// ---------------------------------------------------------------------------
`ifndef NOTE_BIQUAD_CASCADE_FILTERBANK_UNIT_DEFINES_SVH
`define NOTE_BIQUAD_CASCADE_FILTERBANK_UNIT_DEFINES_SVH

// same-cycle implication
`define NBCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NBCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/nbcf_pkg.sv
// ---------------------------------------------------------------------------
// nbcf_pkg
// Types, constants and helpers shared by the filterbank modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package nbcf_pkg;

  localparam int NUM_NOTES          = 128;
  localparam int NUM_CHANNELS       = 2;
  localparam int CLASSES_PER_OCTAVE = 12;
  localparam int SAMPLE_WIDTH       = 24;
  localparam int NUM_COEFS          = 5;

  localparam int NOTE_W   = 7;
  localparam int CH_W     = 1;
  localparam int IDX_W    = 3;
  localparam int CLASS_W  = 4;
  localparam int XSHIFT   = 25 - SAMPLE_WIDTH;
  localparam int COEF_AW  = 1 + NOTE_W + IDX_W;
  localparam int HIST_AW  = 1 + NOTE_W;
  localparam int COEF_DEPTH = 1 << COEF_AW;
  localparam int HIST_DEPTH = 1 << HIST_AW;

  // register map (word index)
  typedef enum logic [2:0] {
    REG_PROT   = 3'd0,
    REG_FIRST  = 3'd1,
    REG_LAST   = 3'd2,
    REG_WET    = 3'd3,
    REG_BOOST  = 3'd4,
    REG_GAIN   = 3'd5
  } reg_idx_e;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_WRCOEF,
    OP_RD,
    OP_MULX,
    OP_Y,
    OP_B1,
    OP_B2,
    OP_A1,
    OP_HWR,
    OP_GAIN,
    OP_RES,
    OP_BYP
  } op_e;

  typedef struct packed {
    logic [11:0] prot;
    logic [NOTE_W-1:0] first_note;
    logic [NOTE_W-1:0] last_note;
    logic        wet;
    logic        boost_en;
    logic [15:0] gain;
  } cfg_t;

  typedef struct packed {
    logic                           cmd;
    logic [CH_W-1:0]                channel;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           bank_select;
    logic [NOTE_W-1:0]              note_number;
    logic [IDX_W-1:0]               coef_index;
    logic signed [31:0]             coef_value;
  } item_t;

  typedef struct packed {
    op_e               op;
    logic              bank;
    logic [NOTE_W-1:0] note;
    logic [IDX_W-1:0]  idx;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // one section's history words, Q8.32
  typedef struct packed {
    logic signed [39:0] s2;
    logic signed [39:0] s1;
  } hist_t;

  typedef hist_t [NUM_CHANNELS-1:0] hist_row_t;

  // note -> pitch class, constant table
  function automatic logic [CLASS_W-1:0] pitch_class(input logic [NOTE_W-1:0] n);
    logic [CLASS_W-1:0] r;
    r = '0;
    for (int i = 0; i < NUM_NOTES; i++) begin
      if (n == NOTE_W'(i)) r = CLASS_W'(i % CLASSES_PER_OCTAVE);
    end
    return r;
  endfunction

  // saturate to a signed width
  function automatic logic signed [63:0] sat_s(input logic signed [63:0] v,
                                               input int unsigned bits);
    logic signed [63:0] lim;
    lim = 64'sd1 <<< (bits - 1);
    if (v > lim - 64'sd1) return lim - 64'sd1;
    else if (v < -lim) return -lim;
    else return v;
  endfunction

endpackage

### rtl/core/nbcf_stream_if.sv
// ---------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for requests into and results out of the filterbank.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nbcf_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic               channel;
  logic signed [23:0] sample_in;
  logic               bank_select;
  logic [6:0]         note_number;
  logic [2:0]         coef_index;
  logic signed [31:0] coef_value;

  modport source (output valid, cmd, channel, sample_in, bank_select, note_number,
                  coef_index, coef_value, input ready);
  modport sink (input valid, cmd, channel, sample_in, bank_select, note_number,
                coef_index, coef_value, output ready);
endinterface

interface nbcf_out_if;
  logic               valid;
  logic               ready;
  logic               out_channel;
  logic signed [23:0] sample_out;

  modport source (output valid, out_channel, sample_out, input ready);
  modport sink (input valid, out_channel, sample_out, output ready);
endinterface

### rtl/core/note_biquad_cascade_filterbank_unit.sv
// ---------------------------------------------------------------------------
// note_biquad_cascade_filterbank_unit
// Per-note peaking biquad filterbank with register port and stream channels.
// ---------------------------------------------------------------------------
// Usage:
//  in_ch carries requests: a sample to filter (cmd 0) or one coefficient
//  write (cmd 1). A coefficient write clears the histories of that
//  section. A sample request gives one result on out_ch. The sequencer
//  walks the 128 cut notes and, if a cut section is active, then the
//  128 boost notes; each active section is stepped through coefficient
//  reads and one shared 32x32 multiplier. A note has at most one active
//  section. A sample with no active cut section gives the bypass result.
//  One sample is in work at a time; in_ch.ready is high only while idle.
//  The result sits in an output register, so a new request is taken while
//  the receiver stalls; the next result waits until that register is free.
//  Reset clears registers, control and all section histories at once.
//  Coefficients are undefined until written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "note_biquad_cascade_filterbank_unit_defines.svh"

module note_biquad_cascade_filterbank_unit (
  input  logic              clk,
  input  logic              rst_n,
  nbcf_in_if.sink           in_ch,
  nbcf_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [4:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import nbcf_pkg::*;

  cfg_t       cfg_r;
  item_t      item_w;
  cmd_t       cmd_w;
  dp_status_t status_w;
  logic       wr_w;
  reg_idx_e   ridx_w;

  assign item_w.cmd         = in_ch.cmd;
  assign item_w.channel     = in_ch.channel;
  assign item_w.sample_in   = in_ch.sample_in;
  assign item_w.bank_select = in_ch.bank_select;
  assign item_w.note_number = in_ch.note_number;
  assign item_w.coef_index  = in_ch.coef_index;
  assign item_w.coef_value  = in_ch.coef_value;

  // register port
  assign cfg_pready = 1'b1;
  assign wr_w   = cfg_psel && cfg_penable && cfg_pwrite;
  assign ridx_w = reg_idx_e'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prot       <= '0;
      cfg_r.first_note <= '0;
      cfg_r.last_note  <= 7'd127;
      cfg_r.wet        <= 1'b0;
      cfg_r.boost_en   <= 1'b0;
      cfg_r.gain       <= 16'd4096;
    end else if (wr_w) begin
      case (ridx_w)
        REG_PROT:  cfg_r.prot       <= cfg_pwdata[11:0];
        REG_FIRST: cfg_r.first_note <= cfg_pwdata[6:0];
        REG_LAST:  cfg_r.last_note  <= cfg_pwdata[6:0];
        REG_WET:   cfg_r.wet        <= cfg_pwdata[0];
        REG_BOOST: cfg_r.boost_en   <= cfg_pwdata[0];
        REG_GAIN:  cfg_r.gain       <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read-back
  always_comb begin
    case (ridx_w)
      REG_PROT:  cfg_prdata = 32'(cfg_r.prot);
      REG_FIRST: cfg_prdata = 32'(cfg_r.first_note);
      REG_LAST:  cfg_prdata = 32'(cfg_r.last_note);
      REG_WET:   cfg_prdata = 32'(cfg_r.wet);
      REG_BOOST: cfg_prdata = 32'(cfg_r.boost_en);
      REG_GAIN:  cfg_prdata = 32'(cfg_r.gain);
      default:   cfg_prdata = '0;
    endcase
  end

  nbcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .item     (item_w),
    .status   (status_w),
    .cmd      (cmd_w)
  );

  nbcf_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd_w),
    .cfg         (cfg_r),
    .item        (item_w),
    .status      (status_w),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_channel (out_ch.out_channel),
    .sample_out  (out_ch.sample_out)
  );

  // checks
  `NBCF_ASSERT_NEXT(a_busy_after_sample, in_ch.valid && in_ch.ready && !in_ch.cmd, !in_ch.ready, "ready stayed high after a sample request")
  `NBCF_ASSERT_NOW(a_result_from_busy, $rose(out_ch.valid), !$past(in_ch.ready), "result appeared without a request in work")
  `NBCF_ASSERT_NEXT(a_coef_wr_stays_idle, in_ch.valid && in_ch.ready && in_ch.cmd, in_ch.ready, "coefficient write left the idle state")

endmodule

### rtl/core/nbcf_ctrl.sv
// ---------------------------------------------------------------------------
// nbcf_ctrl
// Sequencer: scans cut notes, then boost notes if a cut section is active; steps each active section.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbcf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  nbcf_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  nbcf_pkg::item_t     item,
  input  nbcf_pkg::dp_status_t status,
  output nbcf_pkg::cmd_t      cmd
);
  import nbcf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_S0, ST_S1, ST_S2, ST_S3, ST_S4, ST_S5, ST_S6,
    ST_GAIN, ST_RES
  } state_t;

  state_t            state_r, state_nxt;
  logic              bank_r, bank_nxt;
  logic [NOTE_W-1:0] note_r, note_nxt;
  logic              found_r, found_nxt;
  logic              bypass_r, bypass_nxt;

  logic [NOTE_W-1:0] lo_w, hi_w;
  logic              prot_w, inr_w, active_w;

  // section activity for the current bank and note
  always_comb begin
    if (cfg.first_note > cfg.last_note) begin
      lo_w = cfg.last_note;
      hi_w = cfg.first_note;
    end else begin
      lo_w = cfg.first_note;
      hi_w = cfg.last_note;
    end
    prot_w = cfg.prot[pitch_class(note_r)];
    inr_w  = (|cfg.prot) && (note_r >= lo_w) && (note_r <= hi_w);
    if (!bank_r) active_w = inr_w && (cfg.wet ? prot_w : !prot_w);
    else         active_w = inr_w && (cfg.wet ? !prot_w : prot_w) && cfg.boost_en;
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    bank_nxt   = bank_r;
    note_nxt   = note_r;
    found_nxt  = found_r;
    bypass_nxt = bypass_r;
    cmd.op     = OP_NONE;
    cmd.bank   = bank_r;
    cmd.note   = note_r;
    cmd.idx    = '0;
    in_ready   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (item.cmd) begin
            if ((int'(item.coef_index) < NUM_COEFS) &&
                (int'(item.note_number) < NUM_NOTES)) cmd.op = OP_WRCOEF;
          end else if (int'(item.channel) < NUM_CHANNELS) begin
            cmd.op     = OP_LOAD;
            state_nxt  = ST_SCAN;
            bank_nxt   = 1'b0;
            note_nxt   = '0;
            found_nxt  = 1'b0;
            bypass_nxt = 1'b0;
          end
        end
      end
      ST_SCAN, ST_S6: begin
        if (state_r == ST_S6) cmd.op = OP_HWR;
        if ((state_r == ST_SCAN) && active_w) begin
          state_nxt = ST_S0;
          if (!bank_r) found_nxt = 1'b1;
        end else if (int'(note_r) == NUM_NOTES - 1) begin
          if (!bank_r) begin
            if (!found_r) begin
              bypass_nxt = 1'b1;
              state_nxt  = ST_RES;
            end else begin
              bank_nxt  = 1'b1;
              note_nxt  = '0;
              state_nxt = ST_SCAN;
            end
          end else begin
            state_nxt = ST_GAIN;
          end
        end else begin
          note_nxt  = note_r + 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_S0: begin cmd.op = OP_RD;   cmd.idx = 3'd0; state_nxt = ST_S1; end
      ST_S1: begin cmd.op = OP_MULX; cmd.idx = 3'd1; state_nxt = ST_S2; end
      ST_S2: begin cmd.op = OP_Y;    cmd.idx = 3'd2; state_nxt = ST_S3; end
      ST_S3: begin cmd.op = OP_B1;   cmd.idx = 3'd3; state_nxt = ST_S4; end
      ST_S4: begin cmd.op = OP_B2;   cmd.idx = 3'd4; state_nxt = ST_S5; end
      ST_S5: begin cmd.op = OP_A1;   state_nxt = ST_S6; end
      ST_GAIN: begin
        cmd.op    = OP_GAIN;
        state_nxt = ST_RES;
      end
      ST_RES: begin
        if (status.out_free) begin
          cmd.op    = bypass_r ? OP_BYP : OP_RES;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      bank_r   <= 1'b0;
      note_r   <= '0;
      found_r  <= 1'b0;
      bypass_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      bank_r   <= bank_nxt;
      note_r   <= note_nxt;
      found_r  <= found_nxt;
      bypass_r <= bypass_nxt;
    end
  end

endmodule

### rtl/core/nbcf_datapath.sv
// ---------------------------------------------------------------------------
// nbcf_datapath
// Coefficient and history memories, shared multiplier, output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbcf_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  nbcf_pkg::cmd_t      cmd,
  input  nbcf_pkg::cfg_t      cfg,
  input  nbcf_pkg::item_t     item,
  output nbcf_pkg::dp_status_t status,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_channel,
  output logic signed [nbcf_pkg::SAMPLE_WIDTH-1:0] sample_out
);
  import nbcf_pkg::*;

  // memories
  logic signed [31:0] coef_mem [COEF_DEPTH];
  hist_row_t          hist_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] hval_r;

  logic signed [31:0] coef_q_r;
  hist_row_t          hist_q_r;
  logic               hv_q_r;

  // working registers
  logic [CH_W-1:0]                ch_r;
  logic signed [SAMPLE_WIDTH-1:0] dry_r;
  logic signed [31:0]             xin_r, v_r, y_r;
  logic signed [63:0]             prod_r;
  logic signed [57:0]             acc1_r, acc2_r;
  logic signed [49:0]             gprod_r;
  logic                           out_valid_r;
  logic                           out_ch_r;
  logic signed [SAMPLE_WIDTH-1:0] out_smp_r;

  logic signed [55:0] p_w;
  hist_t              h_w, hnew_w;
  hist_row_t          row_w;
  logic signed [56:0] yt_w;
  logic signed [31:0] y_w, mop_w;
  logic signed [57:0] s2t_w;
  logic signed [32:0] vsel_w;
  logic signed [SAMPLE_WIDTH-1:0] res_w;

  // section arithmetic
  always_comb begin
    p_w   = prod_r[63:8];
    h_w   = hv_q_r ? hist_q_r[ch_r] : '0;
    yt_w  = 57'(p_w) + 57'($signed({h_w.s1, 12'b0})) + 57'sd524288;
    y_w   = 32'(sat_s(64'(yt_w >>> 20), 32));
    s2t_w = acc2_r - 58'(p_w);
    hnew_w.s1 = 40'(sat_s(64'((acc1_r + 58'sd2048) >>> 12), 40));
    hnew_w.s2 = 40'(sat_s(64'((s2t_w + 58'sd2048) >>> 12), 40));
    row_w = hv_q_r ? hist_q_r : '0;
    row_w[ch_r] = hnew_w;
    mop_w = ((cmd.op == OP_B2) || (cmd.op == OP_A1)) ? y_r : v_r;
    vsel_w = cfg.wet ? (33'(xin_r) - 33'(v_r)) : 33'(v_r);
    res_w = SAMPLE_WIDTH'(sat_s(64'((gprod_r + 50'sd4096) >>> (37 - SAMPLE_WIDTH)),
                               SAMPLE_WIDTH));
  end

  // coefficient memory
  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRCOEF)
      coef_mem[{item.bank_select, item.note_number, item.coef_index}] <= item.coef_value;
    coef_q_r <= coef_mem[{cmd.bank, cmd.note, cmd.idx}];
  end

  // history memory
  always_ff @(posedge clk) begin
    if (cmd.op == OP_RD) hist_q_r <= hist_mem[{cmd.bank, cmd.note}];
    if (cmd.op == OP_HWR) hist_mem[{cmd.bank, cmd.note}] <= row_w;
  end

  // history valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hval_r <= '0;
      hv_q_r <= 1'b0;
    end else begin
      if (cmd.op == OP_RD) hv_q_r <= hval_r[{cmd.bank, cmd.note}];
      if (cmd.op == OP_WRCOEF) hval_r[{item.bank_select, item.note_number}] <= 1'b0;
      else if (cmd.op == OP_HWR) hval_r[{cmd.bank, cmd.note}] <= 1'b1;
    end
  end

  // multiply and accumulate
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        ch_r  <= item.channel;
        dry_r <= item.sample_in;
        xin_r <= 32'(item.sample_in) <<< XSHIFT;
        v_r   <= 32'(item.sample_in) <<< XSHIFT;
      end
      OP_MULX: prod_r <= 64'(coef_q_r) * 64'(mop_w);
      OP_Y: begin
        y_r    <= y_w;
        prod_r <= 64'(coef_q_r) * 64'(mop_w);
      end
      OP_B1: begin
        acc1_r <= 58'(p_w) + 58'($signed({h_w.s2, 12'b0}));
        prod_r <= 64'(coef_q_r) * 64'(mop_w);
      end
      OP_B2: begin
        acc2_r <= 58'(p_w);
        prod_r <= 64'(coef_q_r) * 64'(mop_w);
      end
      // a2 * y goes out while a1 * y is taken off
      OP_A1: begin
        acc1_r <= acc1_r - 58'(p_w);
        prod_r <= 64'(coef_q_r) * 64'(mop_w);
      end
      OP_HWR: v_r <= y_r;
      OP_GAIN: gprod_r <= 50'(vsel_w) * 50'($signed({1'b0, cfg.gain}));
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.op == OP_RES) || (cmd.op == OP_BYP)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.op == OP_RES) begin
      out_ch_r  <= ch_r;
      out_smp_r <= res_w;
    end else if (cmd.op == OP_BYP) begin
      out_ch_r  <= ch_r;
      out_smp_r <= cfg.wet ? '0 : dry_r;
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid   = out_valid_r;
  assign out_channel = out_ch_r;
  assign sample_out  = out_smp_r;

endmodule

### bench/note_biquad_cascade_filterbank_unit_tb.sv
// ---------------------------------------------------------------------------
// note_biquad_cascade_filterbank_unit_tb
// Drives sample and coefficient requests through the filterbank. A local
// fixed-point filter model predicts every result. Register settings are
// changed between phases, with random idling on both stream sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module note_biquad_cascade_filterbank_unit_tb;
  import nbcf_pkg::*;

  typedef struct {
    bit        ch;
    bit [23:0] smp;
  } eq_result_t;

  // notes that test_load_coefs fills; every range with active sections stays inside
  localparam int LOAD_LO = 48;
  localparam int LOAD_HI = 79;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [4:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  nbcf_in_if in_ch ();
  nbcf_out_if out_ch ();

  note_biquad_cascade_filterbank_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // filter model state
  longint coef_mem [2][NUM_NOTES][NUM_COEFS];
  longint hist_mem [2][NUM_CHANNELS][NUM_NOTES][2];
  bit [11:0] m_prot;
  bit [6:0]  m_first, m_last;
  bit        m_wet, m_boost;
  bit [15:0] m_gain;

  eq_result_t pending_samples[$];
  int  err_cnt;
  bit  calm;
  int  hold_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  function automatic longint sat_to(longint v, int bits);
    longint lim;
    lim = 64'sd1 <<< (bits - 1);
    if (v > lim - 1) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint rnd_shr(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // one transposed direct form II section
  function automatic longint run_biquad(int bank, int ch, int note, longint x);
    longint y, s1, s2;
    y  = sat_to(rnd_shr(((coef_mem[bank][note][0] * x) >>> 8)
                        + hist_mem[bank][ch][note][0] * 4096, 20), 32);
    s1 = ((coef_mem[bank][note][1] * x) >>> 8) - ((coef_mem[bank][note][3] * y) >>> 8)
         + hist_mem[bank][ch][note][1] * 4096;
    s2 = ((coef_mem[bank][note][2] * x) >>> 8) - ((coef_mem[bank][note][4] * y) >>> 8);
    hist_mem[bank][ch][note][0] = sat_to(rnd_shr(s1, 12), 40);
    hist_mem[bank][ch][note][1] = sat_to(rnd_shr(s2, 12), 40);
    return y;
  endfunction

  // update the model for one accepted request
  function automatic void predict_request(item_t it);
    bit cut_on[NUM_NOTES];
    bit boost_on[NUM_NOTES];
    bit any_cut, prot, inr;
    int lo, hi, n, ch;
    longint dry, x, v;
    eq_result_t r;
    ch = it.channel;
    if (it.cmd) begin
      if (it.coef_index < NUM_COEFS) begin
        coef_mem[it.bank_select][it.note_number][it.coef_index] = longint'(it.coef_value);
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          hist_mem[it.bank_select][c][it.note_number][0] = 0;
          hist_mem[it.bank_select][c][it.note_number][1] = 0;
        end
      end
      return;
    end
    lo = m_first; hi = m_last;
    if (lo > hi) begin
      lo = m_last; hi = m_first;
    end
    any_cut = 0;
    for (n = 0; n < NUM_NOTES; n++) begin
      prot = m_prot[n % CLASSES_PER_OCTAVE];
      inr = (m_prot != 0) && n >= lo && n <= hi;
      cut_on[n] = inr && (m_wet ? prot : !prot);
      boost_on[n] = inr && (m_wet ? !prot : prot) && m_boost;
      if (cut_on[n]) any_cut = 1;
    end
    r.ch = it.channel;
    dry = longint'(it.sample_in);
    if (!any_cut) begin
      r.smp = m_wet ? 24'd0 : it.sample_in;
    end else begin
      x = dry <<< XSHIFT;
      v = x;
      for (n = 0; n < NUM_NOTES; n++) if (cut_on[n]) v = run_biquad(0, ch, n, v);
      for (n = 0; n < NUM_NOTES; n++) if (boost_on[n]) v = run_biquad(1, ch, n, v);
      if (m_wet) v = x - v;
      r.smp = 24'(sat_to(rnd_shr(v * longint'(m_gain), 37 - SAMPLE_WIDTH), 24));
    end
    pending_samples = {pending_samples, r};
  endfunction

  // result receiver: random stalls, long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = calm || ($urandom_range(99) >= 37);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    eq_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected result: channel %0d sample %0d",
               out_ch.out_channel, out_ch.sample_out);
        err_cnt++;
      end else begin
        e = pending_samples.pop_front();
        if (out_ch.out_channel !== e.ch) begin
          $error("out_channel: expected %0d actual %0d", e.ch, out_ch.out_channel);
          err_cnt++;
        end
        if (out_ch.sample_out !== e.smp) begin
          $error("sample_out: expected %0d actual %0d",
                 $signed(e.smp), out_ch.sample_out);
          err_cnt++;
        end
      end
    end
  end

  // send one request and wait for it to be taken
  task automatic send_req(input item_t it);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(99) < 37) begin
      in_ch.valid = 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    in_ch.cmd = it.cmd;
    in_ch.channel = it.channel;
    in_ch.sample_in = it.sample_in;
    in_ch.bank_select = it.bank_select;
    in_ch.note_number = it.note_number;
    in_ch.coef_index = it.coef_index;
    in_ch.coef_value = it.coef_value;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_request(it);
  endtask

  task automatic send_sample(input bit ch, input logic [23:0] smp);
    item_t it;
    it.cmd = 1'b0;
    it.channel = ch;
    it.sample_in = smp;
    it.bank_select = 1'($urandom_range(1));
    it.note_number = 7'($urandom_range(127));
    it.coef_index = 3'($urandom_range(7));
    it.coef_value = $urandom;
    send_req(it);
  endtask

  task automatic send_coef(input bit bank, input bit [6:0] note, input bit [2:0] idx,
                           input logic [31:0] val);
    item_t it;
    it.cmd = 1'b1;
    it.channel = 1'($urandom_range(1));
    it.sample_in = 24'($urandom);
    it.bank_select = bank;
    it.note_number = note;
    it.coef_index = idx;
    it.coef_value = val;
    send_req(it);
  endtask

  // let all results arrive, then let a trailing coefficient write finish
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_penable = 1'b0;
    cfg_paddr = {idx, 2'b00}; cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
  endtask

  task automatic set_regs(input bit [11:0] prot, input bit [6:0] first, input bit [6:0] last,
                          input bit wet, input bit boost, input bit [15:0] gain);
    drain_results();
    write_reg(REG_PROT, 32'(prot));   m_prot = prot;
    write_reg(REG_FIRST, 32'(first)); m_first = first;
    write_reg(REG_LAST, 32'(last));   m_last = last;
    write_reg(REG_WET, 32'(wet));     m_wet = wet;
    write_reg(REG_BOOST, 32'(boost)); m_boost = boost;
    write_reg(REG_GAIN, 32'(gain));   m_gain = gain;
  endtask

  // moderate coefficient, occasionally a full-scale one
  function automatic logic [31:0] pick_coef();
    if ($urandom_range(99) < 5) return $urandom;
    return 32'($signed($urandom_range(0, 1 << 28)) - (1 << 27));
  endfunction

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(255));
      default: return 24'($urandom);
    endcase
  endfunction

  // with no pitch class protected every sample passes dry, or as zero when wet
  task automatic test_bypass();
    send_sample(0, 24'h7FFFFF);
    send_sample(1, 24'h800000);
    send_sample(0, 24'h000000);
    send_sample(1, 24'hFFFFFF);
    set_regs(12'h000, 7'd0, 7'd127, 1'b1, 1'b1, 16'hFFFF);
    send_sample(0, 24'h7FFFFF);
    send_sample(1, 24'h123456);
  endtask

  // every section in the loaded notes gets all five coefficients
  task automatic test_load_coefs();
    for (int b = 0; b < 2; b++)
      for (int n = LOAD_LO; n <= LOAD_HI; n++)
        for (int k = 0; k < NUM_COEFS; k++) begin
          if (k == 0) send_coef(1'(b), 7'(n), 3'(k), 32'($urandom_range(1 << 27, 1 << 28)));
          else send_coef(1'(b), 7'(n), 3'(k), pick_coef());
        end
  endtask

  // extremes of registers, coefficients and samples
  task automatic test_directed();
    // all classes protected, not wet: no cut section, so dry passes
    set_regs(12'hFFF, 7'd0, 7'd127, 1'b0, 1'b1, 16'h1000);
    send_sample(0, 24'h400000);
    // reversed range ends, one cut section at note 61, full gain
    set_regs(12'h001, 7'd61, 7'd60, 1'b0, 1'b0, 16'hFFFF);
    send_sample(0, 24'h7FFFFF);
    send_sample(1, 24'h800000);
    // extreme coefficients, out-of-range indexes are ignored
    send_coef(0, 7'd61, 3'd0, 32'h7FFFFFFF);
    send_coef(0, 7'd61, 3'd3, 32'h80000000);
    send_coef(0, 7'd61, 3'd5, 32'h7FFFFFFF);
    send_coef(0, 7'd61, 3'd6, 32'h80000000);
    send_coef(0, 7'd61, 3'd7, 32'h12345678);
    send_sample(0, 24'h7FFFFF);
    send_sample(0, 24'h800000);
    // zero gain
    set_regs(12'h001, 7'd61, 7'd61, 1'b0, 1'b0, 16'h0000);
    send_sample(1, 24'h7FFFFF);
    // wet mode with boost: protected notes cut, others boost
    set_regs(12'h801, 7'd72, 7'd79, 1'b1, 1'b1, 16'h1000);
    send_sample(0, 24'h300000);
    send_sample(1, 24'hC00000);
    // boost bank on for protected notes
    set_regs(12'h0F0, 7'd48, 7'd59, 1'b0, 1'b1, 16'h2000);
    send_sample(0, 24'h7FFFFF);
    send_sample(1, 24'h800000);
  endtask

  // random phases: register settings, samples and coefficient updates
  task automatic test_random();
    int lo_n, hi_n;
    bit [6:0] a, b;
    for (int ph = 0; ph < 9; ph++) begin
      lo_n = $urandom_range(LOAD_LO, LOAD_HI);
      hi_n = lo_n + $urandom_range(10);
      if (hi_n > LOAD_HI) hi_n = LOAD_HI;
      if (ph == 0) begin
        lo_n = LOAD_LO; hi_n = LOAD_HI;
      end
      a = 7'(lo_n);
      b = 7'(hi_n);
      if ($urandom_range(1)) {a, b} = {b, a};
      calm = (ph == 4);
      set_regs(ph == 1 ? 12'hFFF : 12'($urandom), a, b, 1'($urandom_range(1)),
               1'($urandom_range(1)),
               ph == 2 ? 16'hFFFF : 16'($urandom_range(2048, 8192)));
      for (int i = 0; i < 40; i++) begin
        if ($urandom_range(99) < 20)
          send_coef(1'($urandom_range(1)), 7'($urandom_range(127)), 3'($urandom_range(7)),
                    pick_coef());
        else
          send_sample(1'($urandom_range(1)), pick_sample());
      end
    end
    calm = 0;
  endtask

  // receiver holds off so the block fills and stalls its input
  task automatic test_backpressure();
    set_regs(12'h00F, 7'd50, 7'd57, 1'b0, 1'b1, 16'h1000);
    hold_left = 3000;
    for (int i = 0; i < 6; i++) send_sample(1'($urandom_range(1)), pick_sample());
  endtask

  // sender pauses until every result is back
  task automatic test_sender_pause();
    for (int i = 0; i < 4; i++) send_sample(1'($urandom_range(1)), pick_sample());
    drain_results();
    for (int i = 0; i < 4; i++) send_sample(1'($urandom_range(1)), pick_sample());
  endtask

  // main sequence
  initial begin
    err_cnt = 0; calm = 0; hold_left = 0;
    rst_n = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    in_ch.valid = 1'b0; in_ch.cmd = 1'b0; in_ch.channel = 1'b0; in_ch.sample_in = '0;
    in_ch.bank_select = 1'b0; in_ch.note_number = '0; in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    m_prot = 0; m_first = 0; m_last = 127; m_wet = 0; m_boost = 0; m_gain = 16'd4096;
    for (int b = 0; b < 2; b++)
      for (int c = 0; c < NUM_CHANNELS; c++)
        for (int n = 0; n < NUM_NOTES; n++) begin
          hist_mem[b][c][n][0] = 0;
          hist_mem[b][c][n][1] = 0;
        end
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_bypass();
    set_regs(12'h000, 7'd0, 7'd127, 1'b0, 1'b0, 16'h1000);
    test_load_coefs();
    test_directed();
    test_random();
    test_backpressure();
    test_sender_pause();

    drain_results();
    repeat (200) @(posedge clk);
    if (err_cnt == 0 && pending_samples.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
